>>> rtl/core/smh_pkg.sv
// Shared types and constants of the SHA-256 message hasher.
// Used by smh_ctrl, smh_datapath and sha256_message_hasher; depends on nothing.
package smh_pkg;

  // Source of the bytes appended to the block buffer.
  localparam logic [1:0] APP_WORD  = 2'd0;
  localparam logic [1:0] APP_PAD80 = 2'd1;
  localparam logic [1:0] APP_ZERO  = 2'd2;
  localparam logic [1:0] APP_LEN   = 2'd3;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] LEN_OFFSET  = 7'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;        // capture the accepted input word
    logic       app_en;      // append bytes to the block buffer
    logic [1:0] app_sel;     // which bytes to append
    logic       comp_start;  // load working variables, clear fill count
    logic       round_en;    // run one compression round
    logic       fin;         // add working variables into the hash
    logic       part_next;   // one digest part was taken
    logic       msg_done;    // return to the initial hash for a new message
  } smh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [6:0] fill;        // bytes held in the block buffer, 0 to 64
    logic       cnt_zero;    // no bytes of the held word are left
    logic       last;        // the held word closes the message
    logic       round_last;  // the current round is round 63
    logic       part_last;   // the digest part on the output is the fourth
  } smh_status_t;

endpackage

>>> rtl/core/smh_ctrl.sv
// Sequencing state machine of the SHA-256 message hasher.
// Depends on smh_pkg for the command and status structures.
module smh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  smh_pkg::smh_status_t sts,
  output smh_pkg::smh_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_PAD80  = 3'd2;
  localparam logic [2:0] ST_PADZ   = 3'd3;
  localparam logic [2:0] ST_PADLEN = 3'd4;
  localparam logic [2:0] ST_COMP   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic       full;

  assign full = (sts.fill == smh_pkg::BLOCK_BYTES);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (full) begin
          cmd.comp_start = 1'b1;
          ret_nxt        = ST_APPEND;
          state_nxt      = ST_COMP;
        end else if (!sts.cnt_zero) begin
          cmd.app_en  = 1'b1;
          cmd.app_sel = smh_pkg::APP_WORD;
        end else begin
          state_nxt = sts.last ? ST_PAD80 : ST_IDLE;
        end
      end
      ST_PAD80: begin
        if (full) begin
          cmd.comp_start = 1'b1;
          ret_nxt        = ST_PAD80;
          state_nxt      = ST_COMP;
        end else begin
          cmd.app_en  = 1'b1;
          cmd.app_sel = smh_pkg::APP_PAD80;
          state_nxt   = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts.fill == smh_pkg::LEN_OFFSET) begin
          state_nxt = ST_PADLEN;
        end else if (full) begin
          cmd.comp_start = 1'b1;
          ret_nxt        = ST_PADZ;
          state_nxt      = ST_COMP;
        end else begin
          cmd.app_en  = 1'b1;
          cmd.app_sel = smh_pkg::APP_ZERO;
        end
      end
      ST_PADLEN: begin
        if (full) begin
          cmd.comp_start = 1'b1;
          ret_nxt        = ST_OUT;
          state_nxt      = ST_COMP;
        end else begin
          cmd.app_en  = 1'b1;
          cmd.app_sel = smh_pkg::APP_LEN;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        if (sts.round_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.part_next = 1'b1;
          if (sts.part_last) begin
            cmd.msg_done = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

>>> rtl/core/smh_datapath.sv
// Datapath of the SHA-256 message hasher: byte packer, block buffer and
// message schedule, round unit, hash state and digest output select.
// Depends on smh_pkg for constants and the command and status structures.
module smh_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smh_pkg::smh_cmd_t    cmd,
  output smh_pkg::smh_status_t sts,
  input  logic [31:0]          in_word,
  input  logic [2:0]           in_count,
  input  logic                 in_last,
  output logic [63:0]          digest_part,
  output logic [1:0]           part_index
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    ror = (x >> s) | (x << (32 - s));
  endfunction

  // Block buffer, first byte of the block in the top bits; during compression
  // it shifts one word a round and serves as the message schedule.
  logic [511:0] buf_r, buf_nxt;
  logic [31:0]  pend_r, pend_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         last_r, last_nxt;
  logic [6:0]   fill_r, fill_nxt;
  logic [60:0]  len_r, len_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [1:0]   part_r, part_nxt;
  logic [31:0]  hash_r [8];
  logic [31:0]  hash_nxt [8];
  logic [31:0]  wv_r [8];
  logic [31:0]  wv_nxt [8];

  logic [6:0]   room;
  logic [6:0]   gap;
  logic [3:0]   n_word;
  logic [3:0]   n_zero;
  logic [31:0]  word_bytes;
  logic [3:0]   app_n;
  logic [63:0]  app_data;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2;
  logic [2:0]   hi_idx, lo_idx;

  assign room   = smh_pkg::BLOCK_BYTES - fill_r;
  assign n_word = (room < {4'd0, cnt_r}) ? room[3:0] : {1'b0, cnt_r};
  assign gap    = ((fill_r <= smh_pkg::LEN_OFFSET) ? smh_pkg::LEN_OFFSET
                                                   : smh_pkg::BLOCK_BYTES) - fill_r;
  assign n_zero = (gap > 7'd8) ? 4'd8 : gap[3:0];
  assign word_bytes = pend_r >> (6'd32 - {n_word[2:0], 3'b000});

  always_comb begin
    case (cmd.app_sel)
      smh_pkg::APP_WORD: begin
        app_n    = n_word;
        app_data = {32'd0, word_bytes};
      end
      smh_pkg::APP_PAD80: begin
        app_n    = 4'd1;
        app_data = 64'h80;
      end
      smh_pkg::APP_ZERO: begin
        app_n    = n_zero;
        app_data = 64'd0;
      end
      smh_pkg::APP_LEN: begin
        app_n    = 4'd8;
        app_data = {len_r, 3'b000};
      end
      default: begin
        app_n    = 4'd0;
        app_data = 64'd0;
      end
    endcase
  end

  // Schedule taps and round function.
  assign w0  = buf_r[511:480];
  assign w1  = buf_r[479:448];
  assign w9  = buf_r[223:192];
  assign w14 = buf_r[63:32];
  assign w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
               + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;
  assign t1 = wv_r[7] + (ror(wv_r[4], 6) ^ ror(wv_r[4], 11) ^ ror(wv_r[4], 25))
            + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + smh_pkg::ROUND_K[rnd_r] + w0;
  assign t2 = (ror(wv_r[0], 2) ^ ror(wv_r[0], 13) ^ ror(wv_r[0], 22))
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  always_comb begin
    buf_nxt  = buf_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    fill_nxt = fill_r;
    len_nxt  = len_r;
    rnd_nxt  = rnd_r;
    part_nxt = part_r;
    hash_nxt = hash_r;
    wv_nxt   = wv_r;

    if (cmd.load) begin
      pend_nxt = in_word;
      cnt_nxt  = (in_count > 3'd4) ? 3'd4 : in_count;
      last_nxt = in_last;
    end
    if (cmd.app_en) begin
      buf_nxt  = (buf_r << {app_n, 3'b000}) | {448'd0, app_data};
      fill_nxt = fill_r + {3'd0, app_n};
      if (cmd.app_sel == smh_pkg::APP_WORD) begin
        pend_nxt = pend_r << {n_word[2:0], 3'b000};
        cnt_nxt  = cnt_r - n_word[2:0];
        len_nxt  = len_r + {57'd0, n_word};
      end
    end
    if (cmd.comp_start) begin
      fill_nxt = 7'd0;
      rnd_nxt  = 6'd0;
      wv_nxt   = hash_r;
    end
    if (cmd.round_en) begin
      buf_nxt   = {buf_r[479:0], w_new};
      rnd_nxt   = rnd_r + 6'd1;
      wv_nxt[7] = wv_r[6];
      wv_nxt[6] = wv_r[5];
      wv_nxt[5] = wv_r[4];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[3] = wv_r[2];
      wv_nxt[2] = wv_r[1];
      wv_nxt[1] = wv_r[0];
      wv_nxt[0] = t1 + t2;
    end
    if (cmd.fin) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + wv_r[i];
      end
    end
    if (cmd.part_next) begin
      part_nxt = part_r + 2'd1;
    end
    if (cmd.msg_done) begin
      hash_nxt = smh_pkg::INIT_HASH;
      fill_nxt = 7'd0;
      len_nxt  = 61'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 7'd0;
      len_r  <= 61'd0;
      rnd_r  <= 6'd0;
      part_r <= 2'd0;
      cnt_r  <= 3'd0;
      last_r <= 1'b0;
      hash_r <= smh_pkg::INIT_HASH;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    pend_r <= pend_nxt;
    wv_r   <= wv_nxt;
  end

  assign hi_idx      = {part_r, 1'b0};
  assign lo_idx      = {part_r, 1'b1};
  assign digest_part = {hash_r[hi_idx], hash_r[lo_idx]};
  assign part_index  = part_r;

  assign sts.fill       = fill_r;
  assign sts.cnt_zero   = (cnt_r == 3'd0);
  assign sts.last       = last_r;
  assign sts.round_last = (rnd_r == 6'd63);
  assign sts.part_last  = (part_r == 2'd3);

endmodule

>>> rtl/core/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: stream ports, controller and datapath.
// Depends on smh_pkg, smh_ctrl and smh_datapath.

// The hasher takes a message as a stream of big-endian 32-bit words, each with
// a count of valid bytes (left-aligned in the high bits) and a last flag, and
// returns the SHA-256 digest as four 64-bit parts, most significant first, the
// fourth marked by out_tlast. Counts of 5 to 7 are taken as 4, a count of 0
// without last is ignored, and a count of 0 with last closes the message, so an
// empty message can be hashed. Short words need not be last: byte packing just
// continues. The block works on one transaction at a time: a word is taken, its
// bytes are packed into the block buffer (with a compression in between when
// they cross a block boundary), and only then is the next word taken. Each full
// 64-byte block is compressed by the single round unit: the working variables
// are loaded, 64 rounds run, and the variables are added into the hash.
// Closing a message adds the padding (with one or two compressions) and then
// the four digest parts, one per cycle while out_tready is high; no new word is
// taken until the fourth part has left, after which the hasher starts over from
// the initial hash values.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest zero
  input  logic        in_tlast,   // last_word
  // Digest stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_part
  output logic [1:0]  out_tuser,  // [1:0] part_index
  output logic        out_tlast   // last_part
);

  smh_pkg::smh_cmd_t    cmd;
  smh_pkg::smh_status_t sts;

  smh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  smh_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_word     (in_tdata[31:0]),
    .in_count    (in_tdata[34:32]),
    .in_last     (in_tlast),
    .digest_part (out_tdata),
    .part_index  (out_tuser)
  );

  // The fourth part closes the digest.
  assign out_tlast = sts.part_last;

endmodule
